// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the moving average filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside of reset
`define MAF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define MAF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hdl/maf_pkg.sv =====
// ---------------------------------------------------------------------------
// maf_pkg
// Widths, codes and defaults of the moving average filter.
// ---------------------------------------------------------------------------
package maf_pkg;

   localparam int MAX_WINDOW_DEF = 64;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 22;
   localparam int LEN_W    = 7;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FILL = 1'b1;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_WINDOW_LENGTH = 1'b0;

endpackage

// ===== hdl/maf_req_if.sv =====
// ---------------------------------------------------------------------------
// maf_req_if
// Input item channel: operation and sample with valid/ready.
// ---------------------------------------------------------------------------
interface maf_req_if;
   import maf_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ===== hdl/maf_rsp_if.sv =====
// ---------------------------------------------------------------------------
// maf_rsp_if
// Result item channel: average with valid/ready.
// ---------------------------------------------------------------------------
interface maf_rsp_if;
   import maf_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

// ===== hdl/maf_ram.sv =====
// ---------------------------------------------------------------------------
// maf_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/maf_divider.sv =====
// ---------------------------------------------------------------------------
// maf_divider
// Restoring serial divider, one quotient bit per cycle, saturated result.
// ---------------------------------------------------------------------------
module maf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [maf_pkg::SUM_W-1:0]     dividend,
   input  logic [maf_pkg::LEN_W-1:0]     divisor,
   output logic                          done,
   output logic [maf_pkg::SAMPLE_W-1:0]  quotient
);
   import maf_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      ge       = (trial >= {1'b0, div_ff});
      diff     = trial - {1'b0, div_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_W'(SUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits LEN_W bits
         rem_in   = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         quo_in   = {quo_ff[SUM_W-2:0], ge};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[SUM_W-1:SAMPLE_W]) ? '1 : quo_ff[SAMPLE_W-1:0];

endmodule

// ===== hdl/moving_average_filter.sv =====
// ---------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over a ring of samples with a running sum.
// ---------------------------------------------------------------------------
// Each item returns one average: the running sum divided by the window
// length, truncated and saturated to 16 bits. An add item reads the oldest
// sample from the ring, updates the sum and writes the new sample, then the
// shared serial divider produces the quotient one bit at a time. A fill item
// writes the ring one entry a cycle, then starts the same divider. The block
// takes one item at a time; the finished average sits in an output register,
// so the next item is accepted while it waits. After reset the ring is
// zeroed one entry a cycle, all MAX_WINDOW entries, with no item accepted. A
// window_length of 0 acts as 1, one above MAX_WINDOW acts as MAX_WINDOW.
`include "assert_macros.svh"

module moving_average_filter #(
   parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   maf_req_if.sink                         req_chan,
   maf_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [maf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [maf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import maf_pkg::*;

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_FILL   = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_OUTPUT = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    eff_len;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LEN_W-1:0]    item_len_ff, item_len_in;
   logic [SAMPLE_W-1:0] item_sample_ff, item_sample_in;
   logic                div_start_ff, div_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;

   logic                req_fire;
   logic                csr_write;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                div_done;
   logic [SAMPLE_W-1:0] div_quotient;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_WINDOW_LENGTH);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_WINDOW_LENGTH) ?
                       CSR_DATA_W'(len_ff) : '0;

   always_comb begin
      eff_len = len_ff;
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(len_ff) > MAX_WINDOW) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end
   end

   // ---------------- sequencer ----------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      sum_in         = sum_ff;
      item_len_in    = item_len_ff;
      item_sample_in = item_sample_ff;
      div_start_in   = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      avg_in         = avg_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = item_sample_ff;
      ram_rd_en      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = step_ff;
            ram_wr_data = '0;
            if (step_ff == IDX_W'(MAX_WINDOW - 1)) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               item_sample_in = req_chan.sample;
               item_len_in    = eff_len;
               // index left over from a longer window restarts at 0
               if (int'(idx_ff) >= int'(eff_len)) begin
                  idx_in = '0;
               end
               step_in  = '0;
               state_in = (req_chan.operation == OP_FILL) ? ST_FILL : ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_ff + SUM_W'(item_sample_ff) - SUM_W'(ram_rd_data);
            if (int'(idx_ff) + 1 >= int'(item_len_ff)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
            div_start_in = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = step_ff;
            sum_in      = SUM_W'(item_sample_ff) * SUM_W'(item_len_ff);
            if (int'(step_ff) == int'(item_len_ff) - 1) begin
               idx_in       = '0;
               div_start_in = 1'b1;
               state_in     = ST_DIVIDE;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               avg_in       = div_quotient;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= LEN_RESET;
         idx_ff       <= '0;
         step_ff      <= '0;
         sum_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            len_ff <= csr_pwdata[LEN_W-1:0];
         end
      end
      item_len_ff    <= item_len_in;
      item_sample_ff <= item_sample_in;
      avg_ff         <= avg_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.average = avg_ff;

   // ---------------- ring store and divider ----------------
   maf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   maf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (item_len_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- assertions ----------------
   `MAF_ASSERT_ALWAYS(a_accept_drops_ready, (!reset && req_chan.valid && req_chan.ready) |=> !req_chan.ready, "ready stayed high after an accepted item")
   `MAF_ASSERT(a_div_done_in_divide, div_done |-> (state_ff == ST_DIVIDE), "divider finished outside the divide step")
   `MAF_ASSERT(a_rsp_from_output, $rose(rsp_chan.valid) |-> $past(state_ff == ST_OUTPUT), "result raised without a finished division")
   `MAF_ASSERT(a_start_op_match, div_start_ff |-> ($past(state_ff == ST_UPDATE) || $past(state_ff == ST_FILL)), "divider started outside an item")

endmodule

// ===== test/average_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// average_checker
// Watches the item channels and the register port of the moving average
// filter, keeps its own copy of the sample ring, running sum and write
// index, and compares every result item with the predicted average.
// ---------------------------------------------------------------------------
module average_checker
   import maf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   maf_req_if                    req_mon,
   maf_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending
);

   logic [SAMPLE_W-1:0] ring [MAX_WINDOW_DEF];
   logic [SUM_W-1:0]    window_sum;
   logic [5:0]          write_ptr;
   logic [LEN_W-1:0]    window_cfg;
   logic [SAMPLE_W-1:0] expected_averages [$];

   // one item through the filter; returns the average it produces
   task automatic advance_window(input logic op, input logic [SAMPLE_W-1:0] value,
                                 output logic [SAMPLE_W-1:0] avg);
      int unsigned len;
      int unsigned slot;
      logic [SUM_W-1:0] quotient;
      len = (window_cfg == 0) ? 1 :
            (window_cfg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_cfg;
      if (op == OP_ADD) begin
         // index left beyond a shrunk window restarts at zero
         slot = (write_ptr >= len) ? 0 : write_ptr;
         window_sum = window_sum + value - ring[slot];
         ring[slot] = value;
         slot = slot + 1;
         if (slot >= len) slot = 0;
         write_ptr = slot[5:0];
      end else begin
         for (int i = 0; i < len; i++) ring[i] = value;
         window_sum = SUM_W'(value * len);
         write_ptr = '0;
      end
      quotient = window_sum / len;
      avg = (quotient > 22'hFFFF) ? 16'hFFFF : quotient[SAMPLE_W-1:0];
   endtask

   always @(posedge clock) begin : track
      logic [SAMPLE_W-1:0] predicted;
      if (reset) begin
         for (int i = 0; i < MAX_WINDOW_DEF; i++) ring[i] = '0;
         window_sum = '0;
         write_ptr  = '0;
         window_cfg = LEN_RESET;
         expected_averages.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_WINDOW_LENGTH)
            window_cfg = csr_pwdata[LEN_W-1:0];
         if (req_mon.valid && req_mon.ready) begin
            advance_window(req_mon.operation, req_mon.sample, predicted);
            expected_averages.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_averages.size() == 0) begin
               $error("unexpected result item: average %0d", rsp_mon.average);
               fail_count++;
            end else begin
               predicted = expected_averages.pop_front();
               if (rsp_mon.average !== predicted) begin
                  $error("average mismatch: expected %0d, actual %0d",
                         predicted, rsp_mon.average);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_averages.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the moving average filter: a directed pass over extremes,
// window shrink and growth, fills and saturation, then random phases with
// random window lengths, bursty input and a stalling result receiver.
// ---------------------------------------------------------------------------
module tb_top;
   import maf_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    results_taken = 0;
   bit                    draining;

   maf_req_if req_bus();
   maf_rsp_if rsp_bus();

   moving_average_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   average_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) results_taken <= results_taken + 1;
   end

   // offer one item and hold it until it is taken
   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.sample    <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic idle_req(input int cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop offering and wait until every expected average is back
   task automatic drain();
      draining = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      draining = 1'b0;
   endtask

   task automatic write_window(input int unsigned len);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(CSR_IDX_WINDOW_LENGTH) << 2;
      csr_pwdata  <= {25'($urandom), 7'(len)};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // result receiver: changing stall modes, one long hold-off
   initial begin : receiver
      int  stall_mode;
      int  mode_left;
      int  tick;
      bit  long_hold_done;
      stall_mode     = 0;
      mode_left      = 0;
      tick           = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!long_hold_done && results_taken >= 300 && !draining) begin
            rsp_bus.ready <= 1'b0;
            repeat (600) @(negedge clock);
            long_hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((tick % 8) >= 5);
            endcase
         end
      end
   end

   initial begin : stimulus
      int          sent;
      int          phase_items;
      int          burst_left;
      int          pick;
      int unsigned len;
      logic        op;
      logic [SAMPLE_W-1:0] value;
      bit          paused;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_ADD;
      req_bus.sample    = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      draining          = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // ring clearing pass after reset
      repeat (MAX_WINDOW_DEF + 8) @(negedge clock);

      // directed: reset window of 64
      send_item(OP_ADD, 16'hFFFF);
      send_item(OP_ADD, 16'h0000);
      send_item(OP_ADD, 16'hAAAA);
      send_item(OP_ADD, 16'h5555);
      send_item(OP_ADD, 16'h0001);
      send_item(OP_FILL, 16'hFFFF);
      send_item(OP_ADD, 16'h0000);
      send_item(OP_ADD, 16'hFFFF);
      send_item(OP_FILL, 16'h0000);
      send_item(OP_FILL, 16'h8000);
      send_item(OP_ADD, 16'h7FFF);
      drain();
      // shrink to one: sum of a full window saturates, index beyond window
      write_window(1);
      send_item(OP_ADD, 16'd100);
      send_item(OP_ADD, 16'hFFFF);
      send_item(OP_FILL, 16'hFFFF);
      drain();
      write_window(0);
      send_item(OP_ADD, 16'd5);
      send_item(OP_FILL, 16'd7);
      drain();
      // above the maximum; stale entries come back and the sum wraps
      write_window(127);
      send_item(OP_ADD, 16'd0);
      send_item(OP_ADD, 16'd3);
      drain();
      write_window(3);
      send_item(OP_ADD, 16'd1);
      send_item(OP_ADD, 16'd2);
      send_item(OP_ADD, 16'd3);
      send_item(OP_ADD, 16'd4);
      drain();
      write_window(64);
      send_item(OP_ADD, 16'd9);
      drain();

      // random phases
      sent       = 0;
      burst_left = 0;
      paused     = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: len = 1;
            1: len = 64;
            2: len = 0;
            3: len = $urandom_range(65, 127);
            4: len = $urandom_range(2, 8);
            default: len = $urandom_range(1, 64);
         endcase
         write_window(len);
         phase_items = $urandom_range(40, 160);
         for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               if ($urandom_range(0, 2) != 0) idle_req($urandom_range(1, 40));
            end
            burst_left--;
            op = ($urandom_range(0, 7) == 0) ? OP_FILL : OP_ADD;
            pick = $urandom_range(0, 7);
            value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            send_item(op, value);
            sent++;
            if (!paused && sent >= 700) begin
               // sender pause mid-phase until the filter is empty
               drain();
               paused = 1'b1;
            end
         end
         drain();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/maf_pkg.sv
hdl/maf_req_if.sv
hdl/maf_rsp_if.sv
hdl/maf_ram.sv
hdl/maf_divider.sv
hdl/moving_average_filter.sv
test/average_checker.sv
test/tb_top.sv
